@@ sv/ffsa_pkg.sv @@
package ffsa_pkg;

   localparam int HEAP_WORDS_DEF   = 65536;
   localparam int MAX_SEGMENTS_DEF = 64;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_NO_FIT   = 2'd1,
      STATUS_NOT_FOUND = 2'd2,
      STATUS_BAD      = 2'd3
   } status_type;

   localparam logic ACTION_ALLOC = 1'b0;
   localparam logic ACTION_FREE  = 1'b1;

   typedef struct packed {
      logic        action;
      logic [7:0]  thread_id;
      logic [16:0] request_size;
      logic [15:0] block_start;
   } req_type;

   typedef struct packed {
      status_type  status;
      logic [15:0] address;
   } rsp_type;

   // One table entry
   typedef struct packed {
      logic        free;
      logic [7:0]  owner;
      logic [15:0] start;
      logic [16:0] size;
   } seg_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SCAN,
      ST_SCAN_WAIT,
      ST_ALLOC_FIX,
      ST_SHIFT_UP_RD,
      ST_SHIFT_UP_WR,
      ST_FREE_NEXT,
      ST_FREE_PREV,
      ST_MERGE_WR,
      ST_SHIFT_DN_RD,
      ST_SHIFT_DN_WR,
      ST_DONE
   } state_type;

endpackage

@@ sv/ffsa_table.sv @@
// Segment table storage: one write port, one registered read port.
module ffsa_table
   import ffsa_pkg::*;
#(
   parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF,
   localparam int IW = $clog2(MAX_SEGMENTS)
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [IW-1:0] wr_addr,
   input  seg_type       wr_data,
   input  logic [IW-1:0] rd_addr,
   output seg_type       rd_data
);

   seg_type mem [MAX_SEGMENTS];
   seg_type rd_data_ff;

   // Write and read the array
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sv/first_fit_segment_allocator_unit.sv @@
// First-fit heap segment allocator. The address-ordered segment table lives in a synchronous
// memory with one write port and one registered read port, and each request walks it one entry
// at a time, issuing the read of an entry and then checking it, to find its segment; a split that
// inserts an entry or a free merge that removes one then moves each later entry with a read and
// a write. The scan and the moves together cover the table once. One request is handled at a
// time. A write of heap_size reinitializes the table: entry 0 is rewritten and the segment count
// is reset, and stale entries beyond the count are never used; reset rewrites entry 0 the same
// way. The result sits in an output register, so the next request is accepted while it waits to
// be taken.
module first_fit_segment_allocator_unit
   import ffsa_pkg::*;
#(
   parameter int HEAP_WORDS   = HEAP_WORDS_DEF,
   parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data,
   input  logic        csr_we,
   input  logic [16:0] csr_wdata
);

   localparam int IW = $clog2(MAX_SEGMENTS);
   localparam int CW = $clog2(MAX_SEGMENTS + 1);
   localparam logic [16:0] HEAP_MAX = 17'(HEAP_WORDS);

   state_type     state_ff, state_in;
   req_type       req_ff, req_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic [CW-1:0] pos_ff, pos_in;
   seg_type       seg_ff, seg_in;
   logic [16:0]   heap_ff, heap_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_ff, rsp_in;
   rsp_type       res_ff, res_in;

   logic          wr_en;
   logic [IW-1:0] wr_addr;
   seg_type       wr_data;
   logic [IW-1:0] rd_addr;
   seg_type       rd_data;
   logic [16:0]   csr_clip;

   ffsa_table #(.MAX_SEGMENTS(MAX_SEGMENTS)) u_table (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   assign csr_clip = (csr_wdata == 17'd0) ? 17'd1 :
                     (csr_wdata > HEAP_MAX) ? HEAP_MAX : csr_wdata;

   assign req_ready = (state_ff == ST_IDLE) && !reset && !csr_we;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Hold state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= CW'(1);
         heap_ff      <= HEAP_MAX;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         heap_ff      <= heap_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_ff <= req_in;
      idx_ff <= idx_in;
      pos_ff <= pos_in;
      seg_ff <= seg_in;
      rsp_ff <= rsp_in;
      res_ff <= res_in;
   end

   // Sequence scan, split, merge and shifts
   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      pos_in       = pos_ff;
      seg_in       = seg_ff;
      heap_in      = heap_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      res_in       = res_ff;
      wr_en        = 1'b0;
      wr_addr      = IW'(idx_ff);
      wr_data      = seg_ff;
      rd_addr      = IW'(idx_ff);

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (csr_we) begin
               // Reinitialize the table as one free segment
               wr_en    = 1'b1;
               wr_addr  = '0;
               wr_data  = '{free: 1'b1, owner: 8'd0, start: 16'd0, size: csr_clip};
               heap_in  = csr_clip;
               count_in = CW'(1);
            end else if (req_valid && req_ready) begin
               req_in = req_data;
               idx_in = '0;
               if (req_data.action == ACTION_ALLOC && req_data.request_size == 17'd0) begin
                  res_in   = '{status: STATUS_BAD, address: 16'd0};
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            // Issue the read of the current entry, or finish when past the last entry
            if (idx_ff >= count_ff) begin
               res_in = '{status: (req_ff.action == ACTION_ALLOC) ? STATUS_NO_FIT
                                                                   : STATUS_NOT_FOUND,
                          address: 16'd0};
               state_in = ST_DONE;
            end else begin
               rd_addr  = IW'(idx_ff);
               state_in = ST_SCAN_WAIT;
            end
         end
         ST_SCAN_WAIT: begin
            seg_in = rd_data;
            pos_in = idx_ff;
            if (req_ff.action == ACTION_ALLOC) begin
               if (rd_data.free && rd_data.size >= req_ff.request_size) begin
                  state_in = ST_ALLOC_FIX;
               end else begin
                  idx_in   = idx_ff + CW'(1);
                  state_in = ST_SCAN;
               end
            end else begin
               if (!rd_data.free && rd_data.owner == req_ff.thread_id &&
                   rd_data.start == req_ff.block_start) begin
                  // Look at the following entry first
                  idx_in   = idx_ff + CW'(1);
                  rd_addr  = IW'(idx_ff + CW'(1));
                  state_in = ST_FREE_NEXT;
               end else begin
                  idx_in   = idx_ff + CW'(1);
                  state_in = ST_SCAN;
               end
            end
         end
         ST_ALLOC_FIX: begin
            if (seg_ff.size == req_ff.request_size) begin
               wr_en    = 1'b1;
               wr_addr  = IW'(pos_ff);
               wr_data  = '{free: 1'b0, owner: req_ff.thread_id, start: seg_ff.start,
                            size: seg_ff.size};
               res_in   = '{status: STATUS_OK, address: seg_ff.start};
               state_in = ST_DONE;
            end else if (count_ff >= CW'(MAX_SEGMENTS)) begin
               res_in   = '{status: STATUS_BAD, address: 16'd0};
               state_in = ST_DONE;
            end else begin
               // Open a hole at pos+1 by moving entries up from the top
               idx_in   = count_ff;
               state_in = ST_SHIFT_UP_RD;
            end
         end
         ST_SHIFT_UP_RD: begin
            if (idx_ff == pos_ff + CW'(1)) begin
               wr_en    = 1'b1;
               wr_addr  = IW'(pos_ff + CW'(1));
               wr_data  = '{free: 1'b1, owner: 8'd0,
                            start: seg_ff.start + req_ff.request_size[15:0],
                            size: seg_ff.size - req_ff.request_size};
               state_in = ST_SHIFT_UP_WR;
               idx_in   = pos_ff;
            end else begin
               rd_addr  = IW'(idx_ff - CW'(1));
               state_in = ST_SHIFT_UP_WR;
            end
         end
         ST_SHIFT_UP_WR: begin
            if (idx_ff == pos_ff) begin
               wr_en    = 1'b1;
               wr_addr  = IW'(pos_ff);
               wr_data  = '{free: 1'b0, owner: req_ff.thread_id, start: seg_ff.start,
                            size: req_ff.request_size};
               count_in = count_ff + CW'(1);
               res_in   = '{status: STATUS_OK, address: seg_ff.start};
               state_in = ST_DONE;
            end else begin
               wr_en    = 1'b1;
               wr_addr  = IW'(idx_ff);
               wr_data  = rd_data;
               idx_in   = idx_ff - CW'(1);
               state_in = ST_SHIFT_UP_RD;
            end
         end
         ST_FREE_NEXT: begin
            // idx = pos+1, rd_data holds that entry when in range
            seg_in.free  = 1'b1;
            seg_in.owner = 8'd0;
            if (idx_ff < count_ff && rd_data.free) begin
               seg_in.size = seg_ff.size + rd_data.size;
               // Entry pos+1 goes away
               pos_in = pos_ff;
               idx_in = pos_ff + CW'(1);
            end else begin
               idx_in = '0;
            end
            rd_addr  = IW'(pos_ff - CW'(1));
            state_in = ST_FREE_PREV;
         end
         ST_FREE_PREV: begin
            // rd_data holds entry pos-1; idx nonzero marks a removal at idx
            if (pos_ff != '0 && rd_data.free) begin
               seg_in.start = rd_data.start;
               seg_in.size  = rd_data.size + seg_ff.size;
               seg_in.free  = 1'b1;
               seg_in.owner = 8'd0;
               pos_in       = pos_ff - CW'(1);
            end
            state_in = ST_MERGE_WR;
         end
         ST_MERGE_WR: begin
            // Write the merged entry, then drop the absorbed ones
            wr_en   = 1'b1;
            wr_addr = IW'(pos_ff);
            wr_data = seg_ff;
            res_in  = '{status: STATUS_OK, address: 16'd0};
            // Number removed: next merged plus prev merged
            if ((idx_ff != '0) || (req_ff.block_start != seg_ff.start)) begin
               seg_in.size = {15'd0, 2'(idx_ff != '0)} +
                             {15'd0, 2'(req_ff.block_start != seg_ff.start)};
               idx_in   = pos_ff + CW'(1);
               state_in = ST_SHIFT_DN_RD;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_SHIFT_DN_RD: begin
            // Move entry idx+drop down to idx
            if (idx_ff + CW'(seg_ff.size[1:0]) >= count_ff) begin
               count_in = count_ff - CW'(seg_ff.size[1:0]);
               state_in = ST_DONE;
            end else begin
               rd_addr  = IW'(idx_ff + CW'(seg_ff.size[1:0]));
               state_in = ST_SHIFT_DN_WR;
            end
         end
         ST_SHIFT_DN_WR: begin
            wr_en    = 1'b1;
            wr_addr  = IW'(idx_ff);
            wr_data  = rd_data;
            idx_in   = idx_ff + CW'(1);
            state_in = ST_SHIFT_DN_RD;
         end
         ST_DONE: begin
            // Move the result into the output register once it is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_in       = res_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // Rewrite entry 0 as one free segment over the whole heap during reset
      if (reset) begin
         wr_en   = 1'b1;
         wr_addr = '0;
         wr_data = '{free: 1'b1, owner: 8'd0, start: 16'd0, size: HEAP_MAX};
      end
   end

endmodule

@@ sv/ffsa_checker.sv @@
// Port-level checks on the allocator.
module ffsa_checker
   import ffsa_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   // Hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   // A failed request never returns an address
   a_free_addr: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != STATUS_OK |-> rsp_data.address == 16'd0)
      else $error("failed request returned an address");

   // No transfer in the cycle after a transfer is taken
   a_one_at_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second request taken while busy");

   // A result never rises right after a request transfer
   a_rsp_after_req: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(req_valid && req_ready))
      else $error("result raised right after a request transfer");

endmodule

bind first_fit_segment_allocator_unit ffsa_checker u_ffsa_checker (
   .clock    (clock),
   .reset    (reset),
   .req_valid(req_valid),
   .req_ready(req_ready),
   .rsp_valid(rsp_valid),
   .rsp_ready(rsp_ready),
   .rsp_data (rsp_data)
);
